// ===== hw/rtl/y2p_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2p_pkg
// Types and constants shared by the YUYV to planar 4:2:0 converter.
// ----------------------------------------------------------------------------
package y2p_pkg;

	localparam int CFG_W    = 12;
	localparam int SAMPLE_W = 8;
	localparam int ADDR_W   = 22;
	localparam int PLANE_W  = 2;

	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t CFG_FRAME_WIDTH  = 1'b0;
	localparam cfg_idx_t CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
	localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

	typedef enum logic [1:0] {
		BEAT_Y0,
		BEAT_Y1,
		BEAT_U,
		BEAT_V
	} beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] luma_first;
		logic [SAMPLE_W-1:0] chroma_blue;
		logic [SAMPLE_W-1:0] luma_second;
		logic [SAMPLE_W-1:0] chroma_red;
	} pix_t;

	typedef struct packed {
		logic [PLANE_W-1:0]  plane;
		logic [ADDR_W-1:0]   sample_address;
		logic [SAMPLE_W-1:0] sample_value;
		logic                last_of_run;
	} smp_t;

	// One finished pixel pair, ready to be sent as two or four samples.
	typedef struct packed {
		logic                odd_row;
		logic [ADDR_W-1:0]   luma_addr;
		logic [ADDR_W-1:0]   chroma_addr;
		logic [SAMPLE_W-1:0] luma_first;
		logic [SAMPLE_W-1:0] luma_second;
		logic [SAMPLE_W-1:0] u_avg;
		logic [SAMPLE_W-1:0] v_avg;
	} ser_load_t;

endpackage
`default_nettype wire

// ===== hw/rtl/y2p_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2p_stream_if
// Valid/ready stream channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface y2p_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/yuyv_to_planar_420.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuyv_to_planar_420
// Packed YUYV 4:2:2 to planar 4:2:0 sample stream converter.
// ----------------------------------------------------------------------------
// Feed one pixel pair (Y0, U, Y1, V) per transfer on pixels, in raster order.
// Each pair on an even row yields two luma samples; each pair on an odd row
// yields the two luma samples, then U and V, each the truncating average of
// the value stored from the row above and the current one. Every sample on
// samples carries its plane (0 Y, 1 U, 2 V), its offset within the plane and
// a flag on the last sample of the pair. The output port moves one sample per
// cycle while samples.ready is high, and a pair is two samples on even rows
// and four on odd rows; that port sets the sustained rate. A new pair is taken
// while earlier pairs are still in the two pipeline stages or waiting in the
// output register, each pair moving from stage 1 to stage 2 to it. U and V of
// the even row sit in a single-port line memory of MAX_WIDTH/2 entries, read
// in the transfer cycle of the odd-row pair; an entry is always written by an
// earlier transfer than the one that reads it, so no forwarding is needed.
// Write frame_width (index 0) and frame_height (index 1) only while the block
// is idle; odd values drop their low bit and sizes clamp to 2..MAX_*. The line
// memory has no reset: a chroma sample read from a column never written on an
// even row is meaningless.
// ----------------------------------------------------------------------------
module yuyv_to_planar_420 #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire y2p_pkg::cfg_idx_t         cfg_index,
	input  wire logic [y2p_pkg::CFG_W-1:0] cfg_wdata,
	y2p_stream_if.sink                     pixels,
	y2p_stream_if.source                   samples
);
	import y2p_pkg::*;

	// Handoff from the pipeline front to the output register.
	logic      load_valid;
	logic      load_ready;
	ser_load_t load;

	// Counters, line memory, averages and plane addresses.
	y2p_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (pixels.valid),
		.in_ready   (pixels.ready),
		.in_data    (pixels.data),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load       (load)
	);

	// Hold each pair and advance through its samples, one transfer a cycle while samples.ready is high.
	y2p_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load       (load),
		.out_valid  (samples.valid),
		.out_ready  (samples.ready),
		.out_data   (samples.data)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/y2p_line_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2p_line_buf
// Single-port chroma line memory with registered read data.
// ----------------------------------------------------------------------------
module y2p_line_buf #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			line_q[addr] <= wr_data;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= line_q[addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/y2p_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2p_front
// Frame counters, line buffer access, chroma averaging and address products.
// ----------------------------------------------------------------------------
module y2p_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire y2p_pkg::cfg_idx_t            cfg_index,
	input  wire logic [y2p_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire y2p_pkg::pix_t                in_data,
	output logic                              load_valid,
	input  wire logic                         load_ready,
	output y2p_pkg::ser_load_t                load
);
	import y2p_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int COL_W      = $clog2(LINE_DEPTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WS_W       = COL_W + 2;
	localparam int HS_W       = ROW_W + 1;
	localparam int SZ_A       = (CFG_W > WS_W) ? CFG_W : WS_W;
	localparam int SZ_W       = (SZ_A > HS_W) ? SZ_A : HS_W;
	localparam int LB_W       = ROW_W + WS_W;
	localparam int CB_W       = ROW_W + COL_W + 1;

	function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] v,
		input logic [SZ_W-1:0] maxv);
		logic [SZ_W-1:0] e;
		e = {v[SZ_W-1:1], 1'b0};
		if (e < SZ_W'(2)) e = SZ_W'(2);
		if (e > maxv) e = {maxv[SZ_W-1:1], 1'b0};
		return e;
	endfunction

	// Effective (even, clamped) frame size.
	logic [WS_W-1:0]  eff_w_q;
	logic [HS_W-1:0]  eff_h_q;
	logic [COL_W:0]   half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WS_W'(eff_size(SZ_W'(WIDTH_RESET), SZ_W'(MAX_WIDTH)));
			eff_h_q <= HS_W'(eff_size(SZ_W'(HEIGHT_RESET), SZ_W'(MAX_HEIGHT)));
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  eff_w_q <= WS_W'(eff_size(SZ_W'(cfg_wdata),
					SZ_W'(MAX_WIDTH)));
				CFG_FRAME_HEIGHT: eff_h_q <= HS_W'(eff_size(SZ_W'(cfg_wdata),
					SZ_W'(MAX_HEIGHT)));
				default: ;
			endcase
		end
	end

	assign half = eff_w_q[WS_W-1:1];

	// Column and row counters.
	logic [COL_W-1:0] col_q, col_cur, col_nxt;
	logic [ROW_W-1:0] row_q, row_cur, row_nxt;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic             accept;

	always_comb begin
		col_cur = ((COL_W + 1)'(col_q) >= half) ? '0 : col_q;
		row_cur = (HS_W'(row_q) >= eff_h_q) ? '0 : row_q;
		col_inc = (COL_W + 1)'(col_cur) + (COL_W + 1)'(1);
		row_inc = HS_W'(row_cur) + HS_W'(1);
		col_nxt = col_inc[COL_W-1:0];
		row_nxt = row_cur;
		if (col_inc >= half) begin
			col_nxt = '0;
			row_nxt = (row_inc >= eff_h_q) ? '0 : row_inc[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// Even rows write the pair's chroma, odd rows read it back.
	logic [15:0] rd_data;

	y2p_line_buf #(
		.DEPTH  (LINE_DEPTH),
		.ADDR_W (COL_W),
		.DATA_W (16)
	) u_line_buf (
		.clk     (clk),
		.we      (accept && !row_cur[0]),
		.re      (accept && row_cur[0]),
		.addr    (col_cur),
		.wr_data ({in_data.chroma_red, in_data.chroma_blue}),
		.rd_data (rd_data)
	);

	// Stage 1: item registered alongside the line buffer read.
	logic             s1_valid;
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             s2_free;
	logic             s2_valid;

	assign s2_free  = !s2_valid || load_ready;
	assign in_ready = !s1_valid || s2_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= in_data;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
		end
	end

	// Stage 2: plane base products and chroma averages.
	logic [LB_W-1:0]     luma_base_s2;
	logic [CB_W-1:0]     chroma_base_s2;
	logic [COL_W-1:0]    col_s2;
	logic                odd_s2;
	logic [SAMPLE_W-1:0] y0_s2, y1_s2, u_avg_s2, v_avg_s2;
	logic [SAMPLE_W:0]   u_sum, v_sum;
	logic                s2_load;

	assign u_sum   = (SAMPLE_W + 1)'(rd_data[7:0]) + (SAMPLE_W + 1)'(pix_s1.chroma_blue);
	assign v_sum   = (SAMPLE_W + 1)'(rd_data[15:8]) + (SAMPLE_W + 1)'(pix_s1.chroma_red);
	assign s2_load = s1_valid && s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_free) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			luma_base_s2   <= LB_W'(row_s1) * LB_W'(eff_w_q);
			chroma_base_s2 <= CB_W'(row_s1 >> 1) * CB_W'(half);
			col_s2         <= col_s1;
			odd_s2         <= row_s1[0];
			y0_s2          <= pix_s1.luma_first;
			y1_s2          <= pix_s1.luma_second;
			u_avg_s2       <= u_sum[SAMPLE_W:1];
			v_avg_s2       <= v_sum[SAMPLE_W:1];
		end
	end

	assign load_valid = s2_valid;

	always_comb begin
		load.odd_row     = odd_s2;
		load.luma_addr   = ADDR_W'(luma_base_s2 + LB_W'({col_s2, 1'b0}));
		load.chroma_addr = ADDR_W'(chroma_base_s2 + CB_W'(col_s2));
		load.luma_first  = y0_s2;
		load.luma_second = y1_s2;
		load.u_avg       = u_avg_s2;
		load.v_avg       = v_avg_s2;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/y2p_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// y2p_serializer
// Output register that sends one pixel pair as two or four samples.
// ----------------------------------------------------------------------------
module y2p_serializer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load_valid,
	output logic                    load_ready,
	input  wire y2p_pkg::ser_load_t load,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output y2p_pkg::smp_t           out_data
);
	import y2p_pkg::*;

	logic      valid_q;
	beat_t     beat_q, beat_nxt;
	ser_load_t item_q;
	logic      last_beat;
	logic      xfer;

	assign last_beat  = item_q.odd_row ? (beat_q == BEAT_V) : (beat_q == BEAT_Y1);
	assign xfer       = valid_q && out_ready;
	assign load_ready = !valid_q || (out_ready && last_beat);
	assign out_valid  = valid_q;

	always_comb begin
		case (beat_q)
			BEAT_Y0: beat_nxt = BEAT_Y1;
			BEAT_Y1: beat_nxt = BEAT_U;
			BEAT_U:  beat_nxt = BEAT_V;
			default: beat_nxt = BEAT_Y0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_Y0;
		end else if (load_ready) begin
			valid_q <= load_valid;
			beat_q  <= BEAT_Y0;
		end else if (xfer) begin
			beat_q <= beat_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			item_q <= load;
		end
	end

	always_comb begin
		case (beat_q)
			BEAT_Y0: begin
				out_data.plane          = PLANE_Y;
				out_data.sample_address = item_q.luma_addr;
				out_data.sample_value   = item_q.luma_first;
				out_data.last_of_run    = 1'b0;
			end
			BEAT_Y1: begin
				out_data.plane          = PLANE_Y;
				out_data.sample_address = {item_q.luma_addr[ADDR_W-1:1], 1'b1};
				out_data.sample_value   = item_q.luma_second;
				out_data.last_of_run    = !item_q.odd_row;
			end
			BEAT_U: begin
				out_data.plane          = PLANE_U;
				out_data.sample_address = item_q.chroma_addr;
				out_data.sample_value   = item_q.u_avg;
				out_data.last_of_run    = 1'b0;
			end
			default: begin
				out_data.plane          = PLANE_V;
				out_data.sample_address = item_q.chroma_addr;
				out_data.sample_value   = item_q.v_avg;
				out_data.last_of_run    = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== bench/tb_yuyv_to_planar_420.sv =====
// ----------------------------------------------------------------------------
// tb_yuyv_to_planar_420
// Self-checking bench for the YUYV 4:2:2 to planar 4:2:0 converter. A
// directed run covers the reset frame size, sample extremes, averaging
// round-down, odd and out-of-range sizes and counters beyond a shrunk frame.
// Random frame sizes and pixel pairs follow, with random pauses on both
// streams and one long output hold-off. A tracker class predicts every
// sample and checks the sample stream in order.
// ----------------------------------------------------------------------------
module tb_yuyv_to_planar_420;
	import y2p_pkg::*;

	localparam int MAX_W         = 2048;
	localparam int MAX_H         = 2048;
	localparam int LINE_DEPTH    = MAX_W / 2;
	localparam int RANDOM_PAIRS  = 105;
	localparam int HOLD_CYCLES   = 120;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PRINT_CAP     = 50;

	// Tracks frame position, size registers and the chroma line of the block,
	// and keeps the samples still owed on the output stream.
	class i420_tracker;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [15:0]      chroma_row [LINE_DEPTH];
		bit               chroma_seen [LINE_DEPTH];
		int unsigned      col;
		int unsigned      row;
		smp_t             due [$];
		int unsigned      pairs_taken;
		int unsigned      odd_pairs;
		int unsigned      samples_matched;

		function new();
			width_reg       = WIDTH_RESET;
			height_reg      = HEIGHT_RESET;
			col             = 0;
			row             = 0;
			pairs_taken     = 0;
			odd_pairs       = 0;
			samples_matched = 0;
			foreach (chroma_seen[i]) chroma_seen[i] = 1'b0;
		endfunction

		// Drop the low bit, then clamp to 2..limit.
		function int unsigned span(logic [CFG_W-1:0] raw, int unsigned limit);
			int unsigned v;
			v = {raw[CFG_W-1:1], 1'b0};
			if (v < 2) v = 2;
			if (v > limit) v = limit & ~32'd1;
			return v;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			if (idx == CFG_FRAME_WIDTH) width_reg = val;
			else height_reg = val;
		endfunction

		// A new size is safe when the next odd row only reads chroma entries
		// already filled by some even row since reset.
		function bit size_is_safe(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
			int unsigned half;
			int unsigned c;
			int unsigned r;
			half = span(w_raw, MAX_W) / 2;
			c    = (col >= half) ? 0 : col;
			r    = (row >= span(h_raw, MAX_H)) ? 0 : row;
			if (r % 2 == 0) begin
				for (int j = 0; j < c; j++)
					if (!chroma_seen[j]) return 1'b0;
			end else begin
				for (int j = c; j < half; j++)
					if (!chroma_seen[j]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function smp_t sample(logic [PLANE_W-1:0] pl, int unsigned addr,
				logic [SAMPLE_W-1:0] val, logic last);
			smp_t s;
			s.plane          = pl;
			s.sample_address = addr[ADDR_W-1:0];
			s.sample_value   = val;
			s.last_of_run    = last;
			return s;
		endfunction

		// Note one accepted pixel pair and queue the samples it owes.
		function void take_pair(pix_t p);
			int unsigned w;
			int unsigned h;
			int unsigned half;
			int unsigned luma_at;
			int unsigned chroma_at;
			logic [8:0]  u_sum;
			logic [8:0]  v_sum;
			w    = span(width_reg, MAX_W);
			h    = span(height_reg, MAX_H);
			half = w / 2;
			if (col >= half) col = 0;
			if (row >= h) row = 0;
			luma_at = row * w + 2 * col;
			if (row % 2 == 0) begin
				chroma_row[col]  = {p.chroma_red, p.chroma_blue};
				chroma_seen[col] = 1'b1;
				due.push_back(sample(PLANE_Y, luma_at, p.luma_first, 1'b0));
				due.push_back(sample(PLANE_Y, luma_at + 1, p.luma_second, 1'b1));
			end else begin
				chroma_at = (row / 2) * half + col;
				u_sum     = chroma_row[col][7:0] + p.chroma_blue;
				v_sum     = chroma_row[col][15:8] + p.chroma_red;
				due.push_back(sample(PLANE_Y, luma_at, p.luma_first, 1'b0));
				due.push_back(sample(PLANE_Y, luma_at + 1, p.luma_second, 1'b0));
				due.push_back(sample(PLANE_U, chroma_at, u_sum[8:1], 1'b0));
				due.push_back(sample(PLANE_V, chroma_at, v_sum[8:1], 1'b1));
				odd_pairs++;
			end
			col++;
			if (col >= half) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
			pairs_taken++;
		endfunction

		// Compare one sample with the oldest one owed; empty string means match.
		function string match_sample(smp_t got);
			smp_t  want;
			string msg;
			if (due.size() == 0)
				return $sformatf("unexpected sample plane %0d addr %0d value %0d",
					got.plane, got.sample_address, got.sample_value);
			want = due.pop_front();
			msg  = "";
			if (got.plane != want.plane)
				msg = {msg, $sformatf(" plane %0d want %0d", got.plane, want.plane)};
			if (got.sample_address != want.sample_address)
				msg = {msg, $sformatf(" addr %0d want %0d",
					got.sample_address, want.sample_address)};
			if (got.sample_value != want.sample_value)
				msg = {msg, $sformatf(" value %0d want %0d",
					got.sample_value, want.sample_value)};
			if (got.last_of_run != want.last_of_run)
				msg = {msg, $sformatf(" last %0d want %0d", got.last_of_run, want.last_of_run)};
			if (msg == "") begin
				samples_matched++;
				return "";
			end
			return {$sformatf("sample plane %0d addr %0d:", want.plane, want.sample_address), msg};
		endfunction

		function int owed();
			return due.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	y2p_stream_if #(.payload_t(pix_t)) pix_ch ();
	y2p_stream_if #(.payload_t(smp_t)) smp_ch ();

	i420_tracker tracker = new();

	int          errors      = 0;
	int          cfg_writes  = 0;
	int          cycle_count = 0;
	int unsigned widest      = 0;
	bit          hold_req    = 1'b0;
	bit          hold_done   = 1'b0;

	yuyv_to_planar_420 #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pixels   (pix_ch),
		.samples  (smp_ch)
	);

	// 10-unit clock, low first.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples still owed",
				cycle_count, tracker.owed());
			$display("FAIL yuyv_to_planar_420");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		errors++;
		if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
	endtask

	// Check every sample transfer against the oldest owed sample.
	always @(posedge clk) begin : sample_check
		string msg;
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			msg = tracker.match_sample(smp_ch.data);
			if (msg != "") report_mismatch(msg);
		end
	end

	// Output pauses: mostly short, a few long, with long runs of ready in
	// between. On request, hold ready low for one long stretch so the block
	// backs up and stalls its input.
	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 6);
		return $urandom_range(12, 30);
	endfunction

	initial begin : sink_pacing
		int run_left;
		smp_ch.ready = 1'b0;
		run_left     = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				smp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
				run_left  = 0;
			end else if (run_left > 0) begin
				run_left--;
			end else if (smp_ch.ready) begin
				smp_ch.ready <= 1'b0;
				run_left = stall_len() - 1;
			end else begin
				smp_ch.ready <= 1'b1;
				run_left = $urandom_range(0, 40);
			end
		end
	end

	// Input pauses: often none, sometimes a few cycles, rarely long.
	function automatic int pair_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Bias each byte toward its extremes.
	function automatic logic [SAMPLE_W-1:0] byte_value();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	function automatic pix_t random_pair();
		pix_t p;
		p.luma_first  = byte_value();
		p.chroma_blue = byte_value();
		p.luma_second = byte_value();
		p.chroma_red  = byte_value();
		return p;
	endfunction

	// Mostly small sizes; now and then odd, tiny, exact-max or over-range.
	function automatic logic [CFG_W-1:0] pick_size(bit wide);
		case ($urandom_range(0, 19))
			0: begin
				return CFG_W'($urandom_range(0, 3));
			end
			1: begin
				return '1;
			end
			2: begin
				return CFG_W'(2048);
			end
			3: begin
				return CFG_W'(2049);
			end
			4: begin
				return CFG_W'($urandom_range(2, 4095));
			end
			default: begin
				return wide ? CFG_W'($urandom_range(2, 24)) : CFG_W'($urandom_range(2, 12));
			end
		endcase
	endfunction

	// Offer one pair after the given pause and hold it until the transfer.
	task automatic send_pair(pix_t p, int gap);
		@(negedge clk);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.data  <= p;
		do @(posedge clk); while (!pix_ch.ready);
		tracker.take_pair(p);
	endtask

	task automatic offer(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v);
		send_pair({y0, u, y1, v}, pair_gap());
	endtask

	// Drop valid and wait until every owed sample is out, plus a margin so
	// that nothing is still moving through the pipeline.
	task automatic quiesce();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (tracker.owed() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; the enable stays up until the caller closes it, so
	// back-to-back writes never lower and raise it in the same step.
	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic reconfigure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
			bit do_w, bit do_h);
		if (do_w) write_reg(CFG_FRAME_WIDTH, w);
		if (do_h) write_reg(CFG_FRAME_HEIGHT, h);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (tracker.span(tracker.width_reg, MAX_W) > widest)
			widest = tracker.span(tracker.width_reg, MAX_W);
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] w_try;
		logic [CFG_W-1:0] h_try;
		int               mode;
		int               phase_len;
		int               random_sent;
		int               phase_no;
		bit               steady;
		bit               found;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_FRAME_WIDTH;
		cfg_wdata    = '0;
		pix_ch.valid = 1'b0;
		pix_ch.data  = '0;
		widest       = tracker.span(WIDTH_RESET, MAX_W);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset size 640x480: start of the first row, all-zero and all-one
		// bytes and alternating bit patterns.
		offer(8'h00, 8'h00, 8'h00, 8'h00);
		offer(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		offer(8'h55, 8'hAA, 8'hAA, 8'h55);
		quiesce();

		// Shrink to 4x4 with the column already past the new row end: the
		// column must restart at zero. Then a full frame that checks the
		// averages, including round-down, and one pair after the frame wraps.
		reconfigure(12'd4, 12'd4, 1'b1, 1'b1);
		offer(8'd1, 8'hFF, 8'd2, 8'hFF);
		offer(8'd3, 8'h00, 8'd4, 8'h00);
		offer(8'd5, 8'hFF, 8'd6, 8'h00);
		offer(8'd7, 8'h00, 8'd8, 8'hFF);
		offer(8'hFF, 8'h01, 8'h00, 8'h00);
		offer(8'h00, 8'hFE, 8'hFF, 8'hFF);
		offer(8'h80, 8'h02, 8'h7F, 8'hFF);
		offer(8'h7F, 8'hFF, 8'h80, 8'hFF);
		offer(8'h11, 8'h22, 8'h33, 8'h44);
		quiesce();

		// Odd width below the floor and odd height: both fall to 2x2.
		reconfigure(12'd1, 12'd3, 1'b1, 1'b1);
		offer(8'h10, 8'hF0, 8'h20, 8'h0F);
		offer(8'h30, 8'h0F, 8'h40, 8'hF0);
		offer(8'h50, 8'hFF, 8'h60, 8'h01);
		offer(8'h70, 8'h00, 8'h80, 8'hFE);
		quiesce();

		// All-ones width clamps to the maximum row, zero height to 2 rows.
		reconfigure('1, '0, 1'b1, 1'b1);
		offer(8'hA5, 8'h5A, 8'h3C, 8'hC3);
		offer(8'h00, 8'hFF, 8'hFF, 8'h00);
		offer(8'hFF, 8'h00, 8'h00, 8'hFF);
		quiesce();

		// Width 6 leaves the column at the new row end; over-range height
		// clamps to the maximum. One even and one odd row follow.
		reconfigure(12'd6, 12'd4094, 1'b1, 1'b1);
		repeat (6) send_pair(random_pair(), pair_gap());

		// Random part: each phase may change one or both sizes, as long as
		// the next odd row only reads chroma that an even row has filled.
		random_sent = 0;
		phase_no    = 0;
		while (random_sent < RANDOM_PAIRS) begin
			quiesce();
			if ($urandom_range(0, 4) != 0) begin
				found = 1'b0;
				for (int tries = 0; tries < 8 && !found; tries++) begin
					w_try = pick_size(1'b1);
					h_try = pick_size(1'b0);
					mode  = $urandom_range(0, 2);
					if (mode == 1) h_try = tracker.height_reg;
					if (mode == 2) w_try = tracker.width_reg;
					found = tracker.size_is_safe(w_try, h_try);
				end
				if (found) reconfigure(w_try, h_try, mode != 2, mode != 1);
			end
			steady = ($urandom_range(0, 3) == 0);
			// Second phase: stall the output for a long stretch while pairs
			// keep coming back to back.
			if (phase_no == 1) begin
				hold_req = 1'b1;
				steady   = 1'b1;
			end
			phase_len = $urandom_range(6, 24);
			if (phase_len > RANDOM_PAIRS - random_sent) phase_len = RANDOM_PAIRS - random_sent;
			repeat (phase_len) begin
				send_pair(random_pair(), steady ? 0 : pair_gap());
				random_sent++;
			end
			phase_no++;
		end
		quiesce();

		$display("Covered %0d pixel pairs (%0d on odd rows), %0d samples matched, %0d size writes.",
			tracker.pairs_taken, tracker.odd_pairs, tracker.samples_matched, cfg_writes);
		$display("Widest row reached %0d pixels; output held off once for %0d cycles; %0d mismatches.",
			widest, HOLD_CYCLES, errors);
		if (errors == 0) begin
			$display("PASS yuyv_to_planar_420");
		end else begin
			$display("FAIL yuyv_to_planar_420");
		end
		$finish;
	end

endmodule
